// ----- hw/rtl/i2ew_pkg.sv -----
package i2ew_pkg;

   localparam int VALUE_W       = 31;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 10;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 2;
   localparam int STEPS         = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int SHIFT_W       = STEPS * BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(STEPS);
   localparam int WORD_W        = 5;
   localparam int NUM_GROUPS    = 4;
   localparam int SLOTS_PER_GRP = 5;
   localparam int NUM_SLOTS     = NUM_GROUPS * SLOTS_PER_GRP;
   localparam int QUEUE_DEPTH   = 2;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [BCD_W-1:0]   bcd_type;

   // token codes
   localparam word_type TOK_ZERO      = 5'd0;
   localparam word_type TOK_TEN       = 5'd10;
   localparam word_type TOK_TENS_BASE = 5'd18;
   localparam word_type TOK_HUNDRED   = 5'd28;
   localparam word_type TOK_THOUSAND  = 5'd29;
   localparam word_type TOK_MILLION   = 5'd30;
   localparam word_type TOK_BILLION   = 5'd31;

   // slot order inside a group
   localparam int SLOT_HDIGIT  = 0;
   localparam int SLOT_HUNDRED = 1;
   localparam int SLOT_TENS    = 2;
   localparam int SLOT_UNITS   = 3;
   localparam int SLOT_SCALE   = 4;

   typedef struct packed {
      logic    valid;
      bcd_type digits;
   } push_type;

   typedef struct packed {
      logic    full;
      logic    valid;
      bcd_type digits;
   } head_type;

endpackage

// ----- hw/rtl/i2ew_front.sv -----
module i2ew_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [i2ew_pkg::VALUE_W-1:0] req_value,
   input  logic                       q_full,
   output i2ew_pkg::push_type         push
);

   logic                                busy_ff, busy_in;
   logic [i2ew_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [i2ew_pkg::SHIFT_W-1:0]        shreg_ff, shreg_in;
   i2ew_pkg::bcd_type                   bcd_ff, bcd_in;
   i2ew_pkg::bcd_type                   bcd_next;
   logic                                final_step;
   logic                                advance;
   logic                                accept;

   // one double-dabble step: add 3 to any digit of 5 or more, then shift in a bit
   function automatic i2ew_pkg::bcd_type dabble(input i2ew_pkg::bcd_type b, input logic bit_in);
      i2ew_pkg::bcd_type adj;
      adj = b;
      for (int i = 0; i < i2ew_pkg::NUM_DIGITS; i++) begin
         if (b[i*i2ew_pkg::DIGIT_W +: i2ew_pkg::DIGIT_W] >= i2ew_pkg::DIGIT_W'(5)) begin
            adj[i*i2ew_pkg::DIGIT_W +: i2ew_pkg::DIGIT_W] =
               b[i*i2ew_pkg::DIGIT_W +: i2ew_pkg::DIGIT_W] + i2ew_pkg::DIGIT_W'(3);
         end
      end
      return {adj[i2ew_pkg::BCD_W-2:0], bit_in};
   endfunction

   always_comb begin
      bcd_next = bcd_ff;
      for (int k = 0; k < i2ew_pkg::BITS_PER_STEP; k++) begin
         bcd_next = dabble(bcd_next, shreg_ff[i2ew_pkg::SHIFT_W-1-k]);
      end
   end

   assign final_step = busy_ff && (cnt_ff == i2ew_pkg::STEP_CNT_W'(i2ew_pkg::STEPS - 1));
   // stall on the last step until the queue has room
   assign advance    = busy_ff && (!final_step || !q_full);
   assign req_tready = !busy_ff || (final_step && !q_full);
   assign accept     = req_tvalid && req_tready;

   assign push.valid  = final_step && !q_full;
   assign push.digits = bcd_next;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      bcd_in   = bcd_ff;
      if (advance) begin
         cnt_in   = cnt_ff + 1'b1;
         shreg_in = shreg_ff << i2ew_pkg::BITS_PER_STEP;
         bcd_in   = bcd_next;
         if (final_step) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = i2ew_pkg::SHIFT_W'(req_value);
         bcd_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      bcd_ff   <= bcd_in;
   end

endmodule

// ----- hw/rtl/i2ew_queue.sv -----
module i2ew_queue #(
   parameter int DEPTH = i2ew_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  i2ew_pkg::push_type push,
   input  logic               pop,
   output i2ew_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2ew_pkg::bcd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign head.full   = (count_ff == CNT_W'(DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.digits = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !head.full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.digits;
      end
   end

endmodule

// ----- hw/rtl/i2ew_back.sv -----
module i2ew_back (
   input  logic               clock,
   input  logic               reset,
   input  i2ew_pkg::head_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output i2ew_pkg::word_type rsp_word,
   output logic               rsp_last
);

   localparam int NG = i2ew_pkg::NUM_GROUPS;
   localparam int SG = i2ew_pkg::SLOTS_PER_GRP;
   localparam int NS = i2ew_pkg::NUM_SLOTS;
   localparam int DW = i2ew_pkg::DIGIT_W;

   logic                   active_ff, active_in;
   logic [NS-1:0]          mask_ff, mask_in;
   i2ew_pkg::word_type     tok_ff [NS];
   i2ew_pkg::word_type     tok_in [NS];
   logic                   vld_ff, vld_in;
   i2ew_pkg::word_type     word_ff, word_in;
   logic                   last_ff, last_in;

   logic [NS-1:0]          load_mask;
   i2ew_pkg::word_type     load_tok [NS];
   i2ew_pkg::digit_type    gh [NG];
   i2ew_pkg::digit_type    gt [NG];
   i2ew_pkg::digit_type    gu [NG];
   logic                   all_zero;

   logic [NS-1:0]          sel;
   logic [NS-1:0]          rest;
   i2ew_pkg::word_type     sel_tok;
   logic                   emit;
   logic                   load;

   function automatic i2ew_pkg::word_type scale_tok(input int g);
      i2ew_pkg::word_type t;
      unique case (g)
         0:       t = i2ew_pkg::TOK_BILLION;
         1:       t = i2ew_pkg::TOK_MILLION;
         2:       t = i2ew_pkg::TOK_THOUSAND;
         default: t = i2ew_pkg::TOK_ZERO;
      endcase
      return t;
   endfunction

   // groups in spoken order: billions (one digit), millions, thousands, units
   always_comb begin
      gh[0] = '0;
      gt[0] = '0;
      gu[0] = head.digits[9*DW +: DW];
      for (int g = 1; g < NG; g++) begin
         gh[g] = head.digits[(11-3*g)*DW +: DW];
         gt[g] = head.digits[(10-3*g)*DW +: DW];
         gu[g] = head.digits[(9-3*g)*DW +: DW];
      end
   end

   assign all_zero = (head.digits == '0);

   always_comb begin
      logic nz;
      logic tens_word;
      for (int g = 0; g < NG; g++) begin
         nz        = (gh[g] != '0) || (gt[g] != '0) || (gu[g] != '0);
         tens_word = (gt[g] >= DW'(2));
         load_mask[g*SG + i2ew_pkg::SLOT_HDIGIT]  = (gh[g] != '0);
         load_mask[g*SG + i2ew_pkg::SLOT_HUNDRED] = (gh[g] != '0);
         load_mask[g*SG + i2ew_pkg::SLOT_TENS]    = tens_word;
         load_mask[g*SG + i2ew_pkg::SLOT_UNITS]   = tens_word ? (gu[g] != '0)
                                                    : ((gt[g] != '0) || (gu[g] != '0));
         load_mask[g*SG + i2ew_pkg::SLOT_SCALE]   = nz && (g != NG - 1);
         load_tok[g*SG + i2ew_pkg::SLOT_HDIGIT]   = i2ew_pkg::WORD_W'(gh[g]);
         load_tok[g*SG + i2ew_pkg::SLOT_HUNDRED]  = i2ew_pkg::TOK_HUNDRED;
         load_tok[g*SG + i2ew_pkg::SLOT_TENS]     = i2ew_pkg::TOK_TENS_BASE
                                                    + i2ew_pkg::WORD_W'(gt[g]);
         // teens: tens digit is 0 or 1 here
         load_tok[g*SG + i2ew_pkg::SLOT_UNITS]    = tens_word ? i2ew_pkg::WORD_W'(gu[g])
                                                    : i2ew_pkg::WORD_W'(gu[g])
                                                      + (gt[g][0] ? i2ew_pkg::TOK_TEN
                                                                  : i2ew_pkg::TOK_ZERO);
         load_tok[g*SG + i2ew_pkg::SLOT_SCALE]    = scale_tok(g);
      end
      // a value of zero speaks as the single word Zero
      if (all_zero) begin
         load_mask[(NG-1)*SG + i2ew_pkg::SLOT_UNITS] = 1'b1;
      end
   end

   // lowest pending slot goes next
   always_comb begin
      sel     = '0;
      sel_tok = i2ew_pkg::TOK_ZERO;
      for (int i = NS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel     = NS'(1) << i;
            sel_tok = tok_ff[i];
         end
      end
   end

   assign rest = mask_ff & ~sel;
   assign emit = active_ff && (!vld_ff || rsp_tready);
   assign load = head.valid && (!active_ff || (emit && (rest == '0)));
   assign pop  = load;

   always_comb begin
      active_in = active_ff;
      mask_in   = mask_ff;
      tok_in    = tok_ff;
      vld_in    = vld_ff;
      word_in   = word_ff;
      last_in   = last_ff;
      if (emit) begin
         mask_in = rest;
         vld_in  = 1'b1;
         word_in = sel_tok;
         last_in = (rest == '0);
         if (rest == '0) begin
            active_in = 1'b0;
         end
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
      if (load) begin
         active_in = 1'b1;
         mask_in   = load_mask;
         tok_in    = load_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mask_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
         vld_ff    <= vld_in;
      end
      tok_ff  <= tok_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_word   = word_ff;
   assign rsp_last   = last_ff;

endmodule

// ----- hw/rtl/integer_to_english_word_tokens.sv -----
// channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tdata[30:0] value
// rsp     | out | rsp_tvalid/tready  | tdata[4:0] word, tlast = last token of a value
//
// Front end converts each value to decimal, two bits per cycle unless held on its last
// step by a full queue, and the next item is taken in the cycle the previous one enters
// the queue. Back end sends one token per cycle while rsp_tready allows, 1 to 16 tokens
// per item, and loads the next item from the queue as the last token of one goes out.
// Synchronous active-high reset clears control only; no clearing pass.
// A stalled rsp side fills the queue, then stalls the converter and req_tready.
module integer_to_english_word_tokens #(
   parameter int QUEUE_DEPTH = i2ew_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] value, [31] zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] word, [7:5] zero pad
   output logic        rsp_tlast
);

   i2ew_pkg::push_type push;
   i2ew_pkg::head_type head;
   logic               pop;
   i2ew_pkg::word_type rsp_word;

   i2ew_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[i2ew_pkg::VALUE_W-1:0]),
      .q_full     (head.full),
      .push       (push)
   );

   i2ew_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   i2ew_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_word};

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !head.full)
      else $error("converter pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("token sequencer popped an empty queue");

   // a stalled token stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result item changed while stalled");

endmodule
